>>> rtl/evr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants and the quarter-wave sine table for the vertex rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

    // Field widths
    localparam int VTX_W = 8;
    localparam int ANG_W = 9;
    localparam int IDX_W = 7;

    // Fraction bits of the stored table and default trig precision
    localparam int TABLE_FRAC_BITS      = 16;
    localparam int TRIG_FRAC_BITS_DEF   = 14;

    // Quadrant boundaries in whole degrees
    localparam logic [ANG_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANG_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANG_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANG_W-1:0] DEG_360 = 9'd360;

    // sin(d) in Q1.16 for d = 0..90; codes above 90 read as 1.0
    function automatic logic [16:0] sine_q16(input logic [IDX_W-1:0] idx);
        logic [16:0] v;
        unique case (idx)
            7'd0:  v = 17'd0;     7'd1:  v = 17'd1144;  7'd2:  v = 17'd2287;
            7'd3:  v = 17'd3430;  7'd4:  v = 17'd4572;  7'd5:  v = 17'd5712;
            7'd6:  v = 17'd6850;  7'd7:  v = 17'd7987;  7'd8:  v = 17'd9121;
            7'd9:  v = 17'd10252; 7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
            7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
            7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
            7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
            7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
            7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
            7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
            7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
            7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
            7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
            7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
            7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
            7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
            7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
            7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
            7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
            7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
            7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
            7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
            7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
            7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
            7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
            7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
            7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
            7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
            7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
            7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/euler_vertex_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_vertex_rotation
// Rotates a signed vertex about Y, then X, then Z by whole-degree angles,
// using a folded quarter-wave sine table in fixed point.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | word
//  ---------+----------------------------+------------------------------------
//  input    | i_valid / o_stall          | i_vertex_x/y/z, i_angle_x/y/z
//  output   | o_valid / i_stall          | o_rotated_x/y/z
//
//  Five register stages: trig lookup, Y rotation, X rotation, Z rotation,
//  truncate and saturate. One word per cycle is sustained while i_stall is low.
//  The widest multiplier sits in the Z stage, (2F+11) by (F+2) bits.
//  A stage loads whenever it is empty or the one after it moves, so bubbles
//  are squeezed out; o_stall rises only with every stage full and i_stall high.
//  Reset (synchronous) clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_vertex_rotation #(
    parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [evr_pkg::VTX_W-1:0]  i_vertex_x,
    input  logic signed [evr_pkg::VTX_W-1:0]  i_vertex_y,
    input  logic signed [evr_pkg::VTX_W-1:0]  i_vertex_z,
    input  logic [evr_pkg::ANG_W-1:0]         i_angle_x,
    input  logic [evr_pkg::ANG_W-1:0]         i_angle_y,
    input  logic [evr_pkg::ANG_W-1:0]         i_angle_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [evr_pkg::VTX_W-1:0]  o_rotated_x,
    output logic signed [evr_pkg::VTX_W-1:0]  o_rotated_y,
    output logic signed [evr_pkg::VTX_W-1:0]  o_rotated_z
);
    import evr_pkg::*;

    localparam int F     = TRIG_FRAC_BITS;
    localparam int TW    = F + 2;
    localparam int W1    = VTX_W + TW + 1;
    localparam int W2    = 2 * F + 11;
    localparam int W3    = 3 * F + 11;
    localparam int NSTG  = 5;

    // Stage control
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG:1] rdy;

    always_comb begin
        rdy[NSTG] = !r_vld[NSTG] || !i_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[1] = rdy[1] ? i_valid : r_vld[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !rdy[1];
    assign o_valid = r_vld[NSTG];

    // Stage 1: sine/cosine of all three angles
    logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

    evr_trig #(.TRIG_FRAC_BITS(F)) u_trig_x (.i_angle(i_angle_x), .o_sin(sx), .o_cos(cx));
    evr_trig #(.TRIG_FRAC_BITS(F)) u_trig_y (.i_angle(i_angle_y), .o_sin(sy), .o_cos(cy));
    evr_trig #(.TRIG_FRAC_BITS(F)) u_trig_z (.i_angle(i_angle_z), .o_sin(sz), .o_cos(cz));

    logic signed [VTX_W-1:0] r1_x, r1_y, r1_z;
    logic signed [TW-1:0]    r1_sx, r1_cx, r1_sy, r1_cy, r1_sz, r1_cz;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_x  <= i_vertex_x;
            r1_y  <= i_vertex_y;
            r1_z  <= i_vertex_z;
            r1_sx <= sx;
            r1_cx <= cx;
            r1_sy <= sy;
            r1_cy <= cy;
            r1_sz <= sz;
            r1_cz <= cz;
        end
    end

    // Stage 2: about Y, scale 2^F
    logic signed [W1-1:0] rz1, rx1, ry1;

    evr_rot #(.TRIG_FRAC_BITS(F), .IW(VTX_W), .OW(W1)) u_rot_y (
        .i_clk (i_clk),
        .i_en  (rdy[2]),
        .i_p   (r1_z),
        .i_q   (r1_x),
        .i_r   (r1_y),
        .i_sin (r1_sy),
        .i_cos (r1_cy),
        .o_p   (rz1),
        .o_q   (rx1),
        .o_r   (ry1)
    );

    logic signed [TW-1:0] r2_sx, r2_cx, r2_sz, r2_cz;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_sx <= r1_sx;
            r2_cx <= r1_cx;
            r2_sz <= r1_sz;
            r2_cz <= r1_cz;
        end
    end

    // Stage 3: about X, scale 2^2F
    logic signed [W2-1:0] ry2, rz2, rx2;

    evr_rot #(.TRIG_FRAC_BITS(F), .IW(W1), .OW(W2)) u_rot_x (
        .i_clk (i_clk),
        .i_en  (rdy[3]),
        .i_p   (ry1),
        .i_q   (rz1),
        .i_r   (rx1),
        .i_sin (r2_sx),
        .i_cos (r2_cx),
        .o_p   (ry2),
        .o_q   (rz2),
        .o_r   (rx2)
    );

    logic signed [TW-1:0] r3_sz, r3_cz;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_sz <= r2_sz;
            r3_cz <= r2_cz;
        end
    end

    // Stage 4: about Z, scale 2^3F
    logic signed [W3-1:0] rx3, ry3, rz3;

    evr_rot #(.TRIG_FRAC_BITS(F), .IW(W2), .OW(W3)) u_rot_z (
        .i_clk (i_clk),
        .i_en  (rdy[4]),
        .i_p   (rx2),
        .i_q   (ry2),
        .i_r   (rz2),
        .i_sin (r3_sz),
        .i_cos (r3_cz),
        .o_p   (rx3),
        .o_q   (ry3),
        .o_r   (rz3)
    );

    // Stage 5: truncate toward zero, saturate, output register
    logic signed [VTX_W-1:0] n5_x, n5_y, n5_z;
    logic signed [VTX_W-1:0] r5_x, r5_y, r5_z;

    evr_sat #(.TRIG_FRAC_BITS(F), .IW(W3)) u_sat_x (.i_val(rx3), .o_val(n5_x));
    evr_sat #(.TRIG_FRAC_BITS(F), .IW(W3)) u_sat_y (.i_val(ry3), .o_val(n5_y));
    evr_sat #(.TRIG_FRAC_BITS(F), .IW(W3)) u_sat_z (.i_val(rz3), .o_val(n5_z));

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_x <= n5_x;
            r5_y <= n5_y;
            r5_z <= n5_z;
        end
    end

    assign o_rotated_x = r5_x;
    assign o_rotated_y = r5_y;
    assign o_rotated_z = r5_z;

endmodule

>>> rtl/evr_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_trig
// Sine and cosine of a whole-degree angle by quadrant folding of the
// quarter-wave table, rounded to TRIG_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module evr_trig #(
    parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic [evr_pkg::ANG_W-1:0]    i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);
    import evr_pkg::*;

    localparam int TW   = TRIG_FRAC_BITS + 2;
    localparam int SH   = TABLE_FRAC_BITS - TRIG_FRAC_BITS;
    localparam int HALF = (1 << SH) >> 1;

    logic [ANG_W-1:0] ang;
    logic [ANG_W-1:0] s_idx;
    logic [ANG_W-1:0] c_idx;
    logic             s_neg;
    logic             c_neg;
    logic [17:0]      s_sum;
    logic [17:0]      c_sum;
    logic [17:0]      s_shf;
    logic [17:0]      c_shf;
    logic signed [TW-1:0] s_mag;
    logic signed [TW-1:0] c_mag;

    // Wrap codes above 360, then fold into the first quadrant
    always_comb begin
        ang = (i_angle > DEG_360) ? (i_angle - DEG_360) : i_angle;
        if (ang <= DEG_90) begin
            s_idx = ang;            c_idx = DEG_90 - ang;
            s_neg = 1'b0;           c_neg = 1'b0;
        end else if (ang <= DEG_180) begin
            s_idx = DEG_180 - ang;  c_idx = ang - DEG_90;
            s_neg = 1'b0;           c_neg = 1'b1;
        end else if (ang <= DEG_270) begin
            s_idx = ang - DEG_180;  c_idx = DEG_270 - ang;
            s_neg = 1'b1;           c_neg = 1'b1;
        end else begin
            s_idx = DEG_360 - ang;  c_idx = ang - DEG_270;
            s_neg = 1'b1;           c_neg = 1'b0;
        end
    end

    // Table read, round half up to the target precision
    always_comb begin
        s_sum = {1'b0, sine_q16(s_idx[IDX_W-1:0])} + 18'(HALF);
        c_sum = {1'b0, sine_q16(c_idx[IDX_W-1:0])} + 18'(HALF);
        s_shf = s_sum >> SH;
        c_shf = c_sum >> SH;
        s_mag = $signed({1'b0, s_shf[TRIG_FRAC_BITS:0]});
        c_mag = $signed({1'b0, c_shf[TRIG_FRAC_BITS:0]});
    end

    assign o_sin = s_neg ? -s_mag : s_mag;
    assign o_cos = c_neg ? -c_mag : c_mag;

endmodule

>>> rtl/evr_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_rot
// One registered plane rotation: p' = p*c - q*s, q' = p*s + q*c,
// and the untouched axis r' = r * 2^F to keep a common scale.
// ----------------------------------------------------------------------------
module evr_rot #(
    parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_BITS_DEF,
    parameter int IW             = 8,
    parameter int OW             = 25
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [IW-1:0]         i_p,
    input  logic signed [IW-1:0]         i_q,
    input  logic signed [IW-1:0]         i_r,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cos,
    output logic signed [OW-1:0]         o_p,
    output logic signed [OW-1:0]         o_q,
    output logic signed [OW-1:0]         o_r
);
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = IW + TW;

    logic signed [PW-1:0] pc;
    logic signed [PW-1:0] qs;
    logic signed [PW-1:0] ps;
    logic signed [PW-1:0] qc;
    logic signed [PW:0]   sum_p;
    logic signed [PW:0]   sum_q;
    logic signed [OW-1:0] n_p;
    logic signed [OW-1:0] n_q;
    logic signed [OW-1:0] n_r;
    logic signed [OW-1:0] r_p;
    logic signed [OW-1:0] r_q;
    logic signed [OW-1:0] r_r;

    // Four products and the two sums; results fit OW by the rotation bound
    always_comb begin
        pc    = PW'(i_p) * PW'(i_cos);
        qs    = PW'(i_q) * PW'(i_sin);
        ps    = PW'(i_p) * PW'(i_sin);
        qc    = PW'(i_q) * PW'(i_cos);
        sum_p = (PW+1)'(pc) - (PW+1)'(qs);
        sum_q = (PW+1)'(ps) + (PW+1)'(qc);
        n_p   = OW'(sum_p);
        n_q   = OW'(sum_q);
        n_r   = OW'(i_r) <<< TRIG_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_p = r_p;
    assign o_q = r_q;
    assign o_r = r_r;

endmodule

>>> rtl/evr_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_sat
// Drops the 3F fraction bits truncating toward zero and saturates to the
// signed vertex width.
// ----------------------------------------------------------------------------
module evr_sat #(
    parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_BITS_DEF,
    parameter int IW             = 53
) (
    input  logic signed [IW-1:0]                 i_val,
    output logic signed [evr_pkg::VTX_W-1:0]     o_val
);
    import evr_pkg::*;

    localparam int SH = 3 * TRIG_FRAC_BITS;
    localparam int QW = IW + 1 - SH;

    logic [IW-1:0]        bias;
    logic signed [IW:0]   sum;
    logic signed [QW-1:0] quo;
    logic                 ovf_pos;
    logic                 ovf_neg;

    // Negative values get 2^SH - 1 added so the shift rounds toward zero
    always_comb begin
        bias    = i_val[IW-1] ? {{(IW-SH){1'b0}}, {SH{1'b1}}} : '0;
        sum     = $signed({i_val[IW-1], i_val}) + $signed({1'b0, bias});
        quo     = sum[IW:SH];
        ovf_pos = !quo[QW-1] && (|quo[QW-2:VTX_W-1]);
        ovf_neg = quo[QW-1] && !(&quo[QW-2:VTX_W-1]);
        if (ovf_pos) begin
            o_val = {1'b0, {(VTX_W-1){1'b1}}};
        end else if (ovf_neg) begin
            o_val = {1'b1, {(VTX_W-1){1'b0}}};
        end else begin
            o_val = quo[VTX_W-1:0];
        end
    end

endmodule

>>> rtl/evr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_checker
// Port-level checks on the vertex rotator, bound to the top level.
// ----------------------------------------------------------------------------
module evr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_stall,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic signed [evr_pkg::VTX_W-1:0]  o_rotated_x,
    input  logic signed [evr_pkg::VTX_W-1:0]  o_rotated_y,
    input  logic signed [evr_pkg::VTX_W-1:0]  o_rotated_z
);

    // Reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Input back-pressure only when the output is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rotated_x)
            && $stable(o_rotated_y) && $stable(o_rotated_z)))
        else $error("stalled output word changed");

    // Output valid drops only after a word is taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_valid)) |-> $past(!i_stall))
        else $error("output word dropped without being taken");

endmodule

bind euler_vertex_rotation evr_checker u_evr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_rotated_x (o_rotated_x),
    .o_rotated_y (o_rotated_y),
    .o_rotated_z (o_rotated_z)
);
